// ===== hw/rtl/npc_pkg.sv =====
// ============================================================================
// npc_pkg
// Shared widths, codes and types for the nearest palette color search block.
// ============================================================================
package npc_pkg;

    // payload widths
    localparam int COMP_W  = 8;                // stored and requested color component
    localparam int QCOMP_W = 6;                // query component after dropping two lsbs
    localparam int IDX_W   = 8;                // palette index
    localparam int ENTRY_W = 3 * COMP_W;       // packed {red, green, blue}
    localparam int SQ_W    = 2 * COMP_W;       // one squared difference
    localparam int DIST_W  = 18;               // sum of three squares

    // largest reachable distance, 3 * 255 * 255
    localparam logic [DIST_W-1:0] MAX_DIST = DIST_W'(195075);

    // request mode codes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // scan sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_DONE
    } t_state;

    // tag that travels with each palette read down the distance pipeline
    typedef struct packed {
        logic             vld;
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_scan_tag;

endpackage

// ===== hw/rtl/npc_intf.sv =====
// ============================================================================
// npc_intf
// Request and response channels of the nearest palette color search block.
// ============================================================================

// request channel: palette write or nearest color query
interface npc_req_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [npc_pkg::IDX_W-1:0]     entry_index;
    logic [npc_pkg::COMP_W-1:0]    red;
    logic [npc_pkg::COMP_W-1:0]    green;
    logic [npc_pkg::COMP_W-1:0]    blue;

    modport source (
        output valid, mode, entry_index, red, green, blue,
        input  ready
    );
    modport sink (
        input  valid, mode, entry_index, red, green, blue,
        output ready
    );
endinterface

// response channel: nearest index and its distance
interface npc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [npc_pkg::IDX_W-1:0]     closest_index;
    logic [npc_pkg::DIST_W-1:0]    best_distance;

    modport source (
        output valid, closest_index, best_distance,
        input  ready
    );
    modport sink (
        input  valid, closest_index, best_distance,
        output ready
    );
endinterface

// ===== hw/rtl/npc_dist.sv =====
// ============================================================================
// npc_dist
// Two-stage squared euclidean distance between the query color and one
// palette entry: absolute differences and squares, then the sum.
// ============================================================================
module npc_dist (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [npc_pkg::QCOMP_W-1:0]     i_q_red,
    input  logic [npc_pkg::QCOMP_W-1:0]     i_q_green,
    input  logic [npc_pkg::QCOMP_W-1:0]     i_q_blue,
    input  logic [npc_pkg::ENTRY_W-1:0]     i_entry,
    input  npc_pkg::t_scan_tag              i_tag,
    output logic [npc_pkg::DIST_W-1:0]      o_dist,
    output npc_pkg::t_scan_tag              o_tag
);

    localparam int CW = npc_pkg::COMP_W;

    logic [CW-1:0]              w_qr, w_qg, w_qb;
    logic [CW-1:0]              w_er, w_eg, w_eb;
    logic [CW-1:0]              w_dr, w_dg, w_db;
    logic [npc_pkg::SQ_W-1:0]   r_sq_r, r_sq_g, r_sq_b;
    npc_pkg::t_scan_tag         r_sq_tag;
    logic [npc_pkg::DIST_W-1:0] r_dist;
    npc_pkg::t_scan_tag         r_dist_tag;

    // widen the query, split the entry
    assign w_qr = CW'(i_q_red);
    assign w_qg = CW'(i_q_green);
    assign w_qb = CW'(i_q_blue);
    assign w_er = i_entry[3*CW-1:2*CW];
    assign w_eg = i_entry[2*CW-1:CW];
    assign w_eb = i_entry[CW-1:0];

    // absolute component differences
    always_comb begin
        w_dr = (w_qr >= w_er) ? (w_qr - w_er) : (w_er - w_qr);
        w_dg = (w_qg >= w_eg) ? (w_qg - w_eg) : (w_eg - w_qg);
        w_db = (w_qb >= w_eb) ? (w_qb - w_eb) : (w_eb - w_qb);
    end

    // stage 1: squares
    always_ff @(posedge i_clk) begin
        r_sq_r <= w_dr * w_dr;
        r_sq_g <= w_dg * w_dg;
        r_sq_b <= w_db * w_db;
    end

    // stage 2: sum of squares
    always_ff @(posedge i_clk) begin
        r_dist <= npc_pkg::DIST_W'(r_sq_r) + npc_pkg::DIST_W'(r_sq_g)
                + npc_pkg::DIST_W'(r_sq_b);
    end

    // tag pipeline, valid cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_tag   <= '0;
            r_dist_tag <= '0;
        end else begin
            r_sq_tag   <= i_tag;
            r_dist_tag <= r_sq_tag;
        end
    end

    assign o_dist = r_dist;
    assign o_tag  = r_dist_tag;

    // a sum never exceeds three full-range squares
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dist_tag.vld |-> r_dist <= npc_pkg::MAX_DIST)
        else $error("distance out of range");

    // tags move one stage per cycle
    a_tag_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tag.vld |=> ##1 (r_dist_tag.vld && r_dist_tag.idx == $past(i_tag.idx, 2)))
        else $error("tag lost in distance pipeline");

    // last marker only on a valid tag
    a_last_vld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dist_tag.last |-> r_dist_tag.vld)
        else $error("last marker without valid tag");

endmodule

// ===== hw/rtl/nearest_palette_color_unit.sv =====
// ============================================================================
// nearest_palette_color_unit
// Palette memory with a nearest color search by squared euclidean distance.
// ============================================================================
//
//  channel  dir  handshake      payload
//  i_req    in   valid / ready  mode, entry_index, red, green, blue
//  o_rsp    out  valid / ready  closest_index, best_distance
//
//  a palette write keeps the block in the idle state, so it stays ready
//  a query scans with one palette memory read per cycle, then the read,
//  square and sum stages drain; no new request is taken until the result
//  has been loaded into the output register and the block is idle again
//  reset empties the palette at once through per-entry valid bits; an entry
//  never written reads as black, so no clearing pass is needed
//  a waiting result sits in the output register while new requests are taken;
//  a finished query holds in the done state until that register is free
//
module nearest_palette_color_unit #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    npc_req_if.sink      i_req,
    npc_rsp_if.source    o_rsp
);

    localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(PALETTE_ENTRIES - 1);
    localparam int IW = npc_pkg::IDX_W;
    localparam int QW = npc_pkg::QCOMP_W;
    localparam int CW = npc_pkg::COMP_W;

    npc_pkg::t_state              r_state, n_state;
    logic                         w_in_ready, w_issue, w_out_load;
    logic                         w_req_acc, w_query_acc, w_wr_en;

    logic [npc_pkg::ENTRY_W-1:0]  r_mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0]   r_valid;
    logic [npc_pkg::ENTRY_W-1:0]  r_rd_data;
    logic                         r_rd_hit;
    npc_pkg::t_scan_tag           r_rd_tag;
    npc_pkg::t_scan_tag           w_iss_tag;
    logic [npc_pkg::ENTRY_W-1:0]  w_entry;

    logic [AW-1:0]                r_addr;
    logic [QW-1:0]                r_q_red, r_q_green, r_q_blue;

    logic [npc_pkg::DIST_W-1:0]   w_dist;
    npc_pkg::t_scan_tag           w_dist_tag;
    logic [npc_pkg::DIST_W-1:0]   r_best_dist;
    logic [IW-1:0]                r_best_idx;

    logic                         r_out_vld;
    logic [IW-1:0]                r_out_idx;
    logic [npc_pkg::DIST_W-1:0]   r_out_dist;

    // request decode
    assign w_req_acc   = i_req.valid && w_in_ready;
    assign w_query_acc = w_req_acc && (i_req.mode == npc_pkg::MODE_QUERY);
    assign w_wr_en     = w_req_acc && (i_req.mode == npc_pkg::MODE_WRITE)
                       && ({1'b0, i_req.entry_index} < (IW + 1)'(PALETTE_ENTRIES));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            npc_pkg::ST_IDLE: begin
                if (w_query_acc) n_state = npc_pkg::ST_SCAN;
            end
            npc_pkg::ST_SCAN: begin
                if (r_addr == LAST_ADDR) n_state = npc_pkg::ST_WAIT;
            end
            npc_pkg::ST_WAIT: begin
                if (w_dist_tag.vld && w_dist_tag.last) n_state = npc_pkg::ST_DONE;
            end
            npc_pkg::ST_DONE: begin
                if (!r_out_vld || o_rsp.ready) n_state = npc_pkg::ST_IDLE;
            end
            default: n_state = npc_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_in_ready = 1'b0;
        w_issue    = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            npc_pkg::ST_IDLE: w_in_ready = 1'b1;
            npc_pkg::ST_SCAN: w_issue    = 1'b1;
            npc_pkg::ST_WAIT: ;
            npc_pkg::ST_DONE: w_out_load = !r_out_vld || o_rsp.ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= npc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign i_req.ready = w_in_ready;

    // scan address and captured query color
    always_ff @(posedge i_clk) begin
        if (w_query_acc) begin
            r_addr    <= '0;
            r_q_red   <= i_req.red[CW-1:CW-QW];
            r_q_green <= i_req.green[CW-1:CW-QW];
            r_q_blue  <= i_req.blue[CW-1:CW-QW];
        end else if (w_issue) begin
            r_addr <= r_addr + 1'b1;
        end
    end

    // palette memory, one write port and one registered read port;
    // writes only happen while idle, so reads of the scan never overlap them
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[i_req.entry_index[AW-1:0]] <= {i_req.red, i_req.green, i_req.blue};
        end
        r_rd_data <= r_mem[r_addr];
    end

    // per-entry written flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (w_wr_en) r_valid[i_req.entry_index[AW-1:0]] <= 1'b1;
            r_rd_hit <= r_valid[r_addr];
        end
    end

    // tag for each issued read
    always_comb begin
        w_iss_tag.vld  = w_issue;
        w_iss_tag.last = w_issue && (r_addr == LAST_ADDR);
        w_iss_tag.idx  = IW'(r_addr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_tag <= '0;
        end else begin
            r_rd_tag <= w_iss_tag;
        end
    end

    // unwritten entries read as black
    assign w_entry = r_rd_hit ? r_rd_data : '0;

    npc_dist u_dist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_red   (r_q_red),
        .i_q_green (r_q_green),
        .i_q_blue  (r_q_blue),
        .i_entry   (w_entry),
        .i_tag     (r_rd_tag),
        .o_dist    (w_dist),
        .o_tag     (w_dist_tag)
    );

    // running minimum, strict compare keeps the lowest index on ties
    always_ff @(posedge i_clk) begin
        if (w_query_acc) begin
            r_best_dist <= '1;
            r_best_idx  <= '0;
        end else if (w_dist_tag.vld && (w_dist < r_best_dist)) begin
            r_best_dist <= w_dist;
            r_best_idx  <= w_dist_tag.idx;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_idx  <= r_best_idx;
            r_out_dist <= r_best_dist;
        end
    end

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.closest_index = r_out_idx;
    assign o_rsp.best_distance = r_out_dist;

    // the last tag out of the pipeline ends the scan
    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_dist_tag.vld && w_dist_tag.last) |=> r_state == npc_pkg::ST_DONE)
        else $error("scan did not finish on last entry");

    // distance results only arrive while a query is in progress
    a_tag_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dist_tag.vld |-> (r_state == npc_pkg::ST_SCAN || r_state == npc_pkg::ST_WAIT))
        else $error("distance result outside a scan");

    // a delivered result is within the palette and the distance range
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> (r_best_dist <= npc_pkg::MAX_DIST
                        && {1'b0, r_best_idx} < (IW + 1)'(PALETTE_ENTRIES)))
        else $error("result out of range");

    // no write lands in the palette during a scan
    a_no_wr_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> r_state == npc_pkg::ST_IDLE)
        else $error("palette write during scan");

endmodule

// ===== dv/nearest_palette_color_unit_test.sv =====
// ============================================================================
// nearest_palette_color_unit_test
// Self-checking bench for the nearest palette color search. Palette writes
// and color queries are driven with random gaps while responses are
// stalled at random. Each accepted query is answered from a shadow palette,
// and every response is compared field by field, in order.
// ============================================================================
module nearest_palette_color_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PALETTE_ENTRIES = 256;
    localparam int RANDOM_REQS     = 530;
    localparam int STALL_LIMIT     = 4000;
    localparam int SCAN_LATENCY    = PALETTE_ENTRIES + 5;

    // one palette write or query, with the idle time that follows it
    typedef struct {
        logic                       mode;
        logic [npc_pkg::IDX_W-1:0]  entry_index;
        logic [npc_pkg::COMP_W-1:0] red;
        logic [npc_pkg::COMP_W-1:0] green;
        logic [npc_pkg::COMP_W-1:0] blue;
        int                         gap_after;
        bit                         drain_first;
    } t_color_req;

    // answer to one query
    typedef struct {
        logic [npc_pkg::IDX_W-1:0]  closest_index;
        logic [npc_pkg::DIST_W-1:0] best_distance;
    } t_palette_hit;

    logic i_clk;
    logic i_rst_n;

    npc_req_if req_ch ();
    npc_rsp_if rsp_ch ();

    nearest_palette_color_unit #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    t_color_req                  req_backlog[$];
    t_palette_hit                pending_answers[$];
    logic [npc_pkg::ENTRY_W-1:0] shadow_palette [PALETTE_ENTRIES];
    logic [npc_pkg::COMP_W-1:0]  planned_palette [PALETTE_ENTRIES][3];
    int                          mismatch_count = 0;
    int                          send_gap_left;
    int                          send_calm_left = 0;
    int                          stall_left;
    int                          stall_calm_left;
    int                          quiet_cycles;

    // clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 40);
    endfunction

    // search the shadow palette, lowest index wins on equal distance
    function automatic t_palette_hit nearest_entry(input logic [npc_pkg::COMP_W-1:0] r,
                                                   input logic [npc_pkg::COMP_W-1:0] g,
                                                   input logic [npc_pkg::COMP_W-1:0] b);
        t_palette_hit hit;
        int best;
        int sum_sq;
        int dr;
        int dg;
        int db;
        best = 32'h7fff_ffff;
        hit.closest_index = '0;
        for (int i = 0; i < PALETTE_ENTRIES; i++) begin
            dr = int'(r >> 2) - int'(shadow_palette[i][23:16]);
            dg = int'(g >> 2) - int'(shadow_palette[i][15:8]);
            db = int'(b >> 2) - int'(shadow_palette[i][7:0]);
            sum_sq = dr * dr + dg * dg + db * db;
            if (sum_sq < best) begin
                best = sum_sq;
                hit.closest_index = npc_pkg::IDX_W'(i);
            end
        end
        hit.best_distance = npc_pkg::DIST_W'(best);
        return hit;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // queue one request; calm stretches get no idle time at all
    task automatic add_req(input logic mode, input int idx, input int r,
                           input int g, input int b, input bit drain);
        t_color_req item;
        item.mode        = mode;
        item.entry_index = npc_pkg::IDX_W'(idx);
        item.red         = npc_pkg::COMP_W'(r);
        item.green       = npc_pkg::COMP_W'(g);
        item.blue        = npc_pkg::COMP_W'(b);
        item.drain_first = drain;
        if (send_calm_left > 0) begin
            send_calm_left--;
            item.gap_after = 0;
        end else if ($urandom_range(0, 39) == 0) begin
            send_calm_left = $urandom_range(20, 60);
            item.gap_after = 0;
        end else begin
            item.gap_after = pick_gap();
        end
        if (mode == npc_pkg::MODE_WRITE) begin
            planned_palette[idx][0] = npc_pkg::COMP_W'(r);
            planned_palette[idx][1] = npc_pkg::COMP_W'(g);
            planned_palette[idx][2] = npc_pkg::COMP_W'(b);
        end
        req_backlog.push_back(item);
    endtask

    // query aimed near a planned entry, low bits and small offsets random
    task automatic add_near_query(input bit wiggle);
        int k;
        int c [3];
        k = $urandom_range(0, PALETTE_ENTRIES - 1);
        for (int j = 0; j < 3; j++) begin
            c[j] = planned_palette[k][j] % 64;
            if (wiggle) begin
                c[j] = c[j] + $urandom_range(0, 4) - 2;
                c[j] = (c[j] < 0) ? 0 : ((c[j] > 63) ? 63 : c[j]);
            end
            c[j] = c[j] * 4 + $urandom_range(0, 3);
        end
        add_req(npc_pkg::MODE_QUERY, $urandom_range(0, 255), c[0], c[1], c[2], 1'b0);
    endtask

    // stimulus, reset and end of run
    initial begin
        int roll;
        int src;
        i_rst_n = 1'b0;
        for (int i = 0; i < PALETTE_ENTRIES; i++) begin
            for (int j = 0; j < 3; j++) begin
                planned_palette[i][j] = '0;
            end
        end

        // untouched palette: everything is black, index 0 answers
        add_req(npc_pkg::MODE_QUERY, 8'h00, 8'hff, 8'hff, 8'hff, 1'b0);
        add_req(npc_pkg::MODE_QUERY, 8'hff, 8'h00, 8'h00, 8'h00, 1'b0);
        // extremes of the stored components
        add_req(npc_pkg::MODE_WRITE, 255, 8'hff, 8'hff, 8'hff, 1'b0);
        add_req(npc_pkg::MODE_WRITE, 128, 8'h3f, 8'h3f, 8'h3f, 1'b0);
        add_req(npc_pkg::MODE_QUERY, 8'h00, 8'hff, 8'hff, 8'hff, 1'b0);
        add_req(npc_pkg::MODE_QUERY, 8'h55, 8'hfc, 8'hfc, 8'hfc, 1'b0);
        add_req(npc_pkg::MODE_WRITE, 0, 8'hff, 8'h00, 8'haa, 1'b0);
        add_req(npc_pkg::MODE_WRITE, 1, 8'h00, 8'hff, 8'h55, 1'b0);
        // low query bits are dropped, so this hits the first black entry
        add_req(npc_pkg::MODE_QUERY, 8'haa, 8'h03, 8'h03, 8'h03, 1'b1);
        // identical entries: the lower index wins
        add_req(npc_pkg::MODE_WRITE, 20, 8'h28, 8'h28, 8'h28, 1'b0);
        add_req(npc_pkg::MODE_WRITE, 10, 8'h28, 8'h28, 8'h28, 1'b0);
        add_req(npc_pkg::MODE_QUERY, 8'h0f, 8'ha0, 8'ha0, 8'ha0, 1'b0);
        // equal sums from different components
        add_req(npc_pkg::MODE_WRITE, 10, 8'hff, 8'hff, 8'hff, 1'b1);
        add_req(npc_pkg::MODE_WRITE, 20, 8'hff, 8'hff, 8'hff, 1'b0);
        add_req(npc_pkg::MODE_WRITE, 41, 8'h28, 8'h27, 8'h28, 1'b0);
        add_req(npc_pkg::MODE_WRITE, 40, 8'h29, 8'h28, 8'h28, 1'b0);
        add_req(npc_pkg::MODE_QUERY, 8'hf0, 8'ha3, 8'ha2, 8'ha1, 1'b0);
        // overwrite the top entry back to black, then query far away
        add_req(npc_pkg::MODE_WRITE, 255, 8'h00, 8'h00, 8'h00, 1'b0);
        add_req(npc_pkg::MODE_QUERY, 8'hff, 8'h80, 8'h7f, 8'h01, 1'b1);

        // random writes and queries
        for (int n = 0; n < RANDOM_REQS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 22) begin
                add_req(npc_pkg::MODE_WRITE, $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 59) == 0);
            end else if (roll < 44) begin
                add_req(npc_pkg::MODE_WRITE, $urandom_range(0, 255), $urandom_range(0, 63),
                        $urandom_range(0, 63), $urandom_range(0, 63),
                        $urandom_range(0, 59) == 0);
            end else if (roll < 55) begin
                src = $urandom_range(0, PALETTE_ENTRIES - 1);
                add_req(npc_pkg::MODE_WRITE, $urandom_range(0, 255), planned_palette[src][0],
                        planned_palette[src][1], planned_palette[src][2], 1'b0);
            end else if (roll < 69) begin
                add_req(npc_pkg::MODE_QUERY, $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 39) == 0);
            end else if (roll < 85) begin
                add_near_query(1'b0);
            end else begin
                add_near_query(1'b1);
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_backlog.size() != 0 || req_ch.valid || pending_answers.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SCAN_LATENCY + 16) @(posedge i_clk);
        if (pending_answers.size() != 0) begin
            report_mismatch($sformatf("%0d queries never answered", pending_answers.size()));
        end
        if (mismatch_count == 0) begin
            $display("nearest_palette_color_unit regression: pass");
        end else begin
            $display("nearest_palette_color_unit regression: fail");
        end
        $finish;
    end

    // request driver and shadow palette update
    always @(posedge i_clk) begin
        t_color_req item;
        if (!i_rst_n) begin
            for (int i = 0; i < PALETTE_ENTRIES; i++) begin
                shadow_palette[i] = '0;
            end
            req_ch.valid       <= 1'b0;
            req_ch.mode        <= npc_pkg::MODE_WRITE;
            req_ch.entry_index <= '0;
            req_ch.red         <= '0;
            req_ch.green       <= '0;
            req_ch.blue        <= '0;
            send_gap_left      <= 0;
        end else begin
            // accepted request: update the palette or predict the answer
            if (req_ch.valid && req_ch.ready) begin
                if (req_ch.mode == npc_pkg::MODE_WRITE) begin
                    if (int'(req_ch.entry_index) < PALETTE_ENTRIES) begin
                        shadow_palette[req_ch.entry_index] =
                            {req_ch.red, req_ch.green, req_ch.blue};
                    end
                end else begin
                    pending_answers.push_back(
                        nearest_entry(req_ch.red, req_ch.green, req_ch.blue));
                end
            end
            // next request once the channel is free
            if (!req_ch.valid || req_ch.ready) begin
                if (send_gap_left > 0) begin
                    send_gap_left <= send_gap_left - 1;
                    req_ch.valid  <= 1'b0;
                end else if (req_backlog.size() != 0 &&
                             !(req_backlog[0].drain_first && pending_answers.size() != 0)) begin
                    item = req_backlog.pop_front();
                    req_ch.valid       <= 1'b1;
                    req_ch.mode        <= item.mode;
                    req_ch.entry_index <= item.entry_index;
                    req_ch.red         <= item.red;
                    req_ch.green       <= item.green;
                    req_ch.blue        <= item.blue;
                    send_gap_left      <= item.gap_after;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // response monitor with random back pressure
    always @(posedge i_clk) begin
        t_palette_hit want;
        if (!i_rst_n) begin
            rsp_ch.ready    <= 1'b0;
            stall_left      <= 0;
            stall_calm_left <= 0;
        end else begin
            // compare against the oldest outstanding query
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (pending_answers.size() == 0) begin
                    report_mismatch($sformatf("response idx %0d dist %0d with no query",
                                              rsp_ch.closest_index, rsp_ch.best_distance));
                end else begin
                    want = pending_answers.pop_front();
                    if (rsp_ch.closest_index !== want.closest_index) begin
                        report_mismatch($sformatf("closest_index %0d, want %0d",
                                                  rsp_ch.closest_index, want.closest_index));
                    end
                    if (rsp_ch.best_distance !== want.best_distance) begin
                        report_mismatch($sformatf("best_distance %0d, want %0d",
                                                  rsp_ch.best_distance, want.best_distance));
                    end
                end
            end
            // ready pattern
            if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left   <= stall_left - 1;
            end else begin
                rsp_ch.ready <= 1'b1;
                if (stall_calm_left > 0) begin
                    stall_calm_left <= stall_calm_left - 1;
                end else if ($urandom_range(0, 299) == 0) begin
                    stall_calm_left <= $urandom_range(100, 1500);
                end else if ($urandom_range(0, 3) == 0) begin
                    stall_left <= pick_gap();
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[%0t] no transfer for %0d cycles", $realtime, quiet_cycles);
            $display("nearest_palette_color_unit regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
